>>> rtl/first_fit_coalescing_allocator_unit_defines.svh
// ----------------------------------------------------------------------------
// first_fit_coalescing_allocator_unit_defines
// assertion macros used by the allocator port checker
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_COALESCING_ALLOCATOR_UNIT_DEFINES_SVH
`define FIRST_FIT_COALESCING_ALLOCATOR_UNIT_DEFINES_SVH

// property checked on every clock edge outside reset
`define FFCA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property that must also hold across reset
`define FFCA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/ffca_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffca_pkg
// shared constants, codes and control structs of the allocator
// ----------------------------------------------------------------------------
package ffca_pkg;

  localparam int TBL_DEPTH = 32;
  localparam int CNT_W     = 6;
  localparam int ADDR_W    = 20;
  localparam int SIZE_W    = 21;

  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_FREE   = 2'd1;
  localparam logic [1:0] OP_RESIZE = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_KEPT  = 3'd1;
  localparam logic [2:0] ST_MOVED = 3'd2;
  localparam logic [2:0] ST_OOM   = 3'd3;
  localparam logic [2:0] ST_FULL  = 3'd4;

  localparam logic [21:0] HDR_BYTES      = 22'd16;
  localparam logic [21:0] FREE_HDR_BYTES = 22'd32;
  localparam logic [20:0] HEAP_MIN       = 21'd64;
  localparam logic [20:0] HEAP_MAX       = 21'h100000;
  localparam logic [20:0] HEAP_RST       = 21'd65536;
  localparam logic [20:0] CNT_MAX        = 21'h1FFFFF;
  localparam logic [CNT_W-1:0] TBL_FULL  = 6'd32;

  typedef struct packed {
    logic       capture;
    logic       fit;
    logic       take;
    logic       load_split;
    logic       load_free;
    logic       prep;
    logic       apply;
    logic       used_sub;
    logic       set_st;
    logic [2:0] st;
    logic       res_zero;
    logic       res_keep;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       addr_none;
    logic       fits_inplace;
    logic       fr_ok;
    logic       fit_any;
    logic       split;
    logic       add_ok;
    logic       out_busy;
  } dp_stat_t;

endpackage

>>> rtl/first_fit_coalescing_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_coalescing_allocator_unit
// first-fit heap allocator over an address-sorted table of free blocks
// ----------------------------------------------------------------------------
// One item at a time. The controller steps each request through decide,
// then for an allocate or a moving resize search and take, and then the
// prep and apply steps of the free-table insert, whose rows all update in
// parallel: once for a split or a free, twice for a split resize that also
// frees its old block. The result sits in an output register, so a
// stalled result only holds back the next item once that item has its own
// result ready. Writing the heap size reloads the table as one free block
// and clears used bytes.
module first_fit_coalescing_allocator_unit import ffca_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // heap size in bytes
  input  logic        cfg_wr_en,
  input  logic [20:0] cfg_wr_data,
  // request item
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // request_size, block_address, block_size
  input  logic [1:0]  in_tuser,   // operation
  // result item
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // payload_address, granted_bytes, used_bytes, peak_bytes
  output logic [2:0]  out_tuser   // status
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: one step of the table operation per state
  ffca_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // free table, counters and result register
  ffca_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_op       (in_tuser),
    .in_req      (in_tdata[20:0]),
    .in_addr     (in_tdata[40:21]),
    .in_bsz      (in_tdata[61:41]),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

endmodule

>>> rtl/ffca_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffca_ctrl
// sequencer for allocate, free and resize over the free table datapath
// ----------------------------------------------------------------------------
module ffca_ctrl import ffca_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_FIT    = 3'd2;
  localparam logic [2:0] S_TAKE   = 3'd3;
  localparam logic [2:0] S_PREP   = 3'd4;
  localparam logic [2:0] S_APPLY  = 3'd5;
  localparam logic [2:0] S_RESP   = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       phase_free_r, phase_free_nxt;
  logic       need_free;

  assign in_tready = (state_r == S_IDLE);
  assign need_free = (stat.op == OP_RESIZE) && !stat.addr_none;

  always_comb begin
    cmd            = '0;
    state_nxt      = state_r;
    phase_free_nxt = phase_free_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.op == OP_NONE) begin
          cmd.set_st   = 1'b1;
          cmd.st       = ST_OK;
          cmd.res_zero = 1'b1;
          state_nxt    = S_RESP;
        end else if (stat.op == OP_FREE) begin
          cmd.set_st   = 1'b1;
          cmd.st       = ST_OK;
          cmd.res_zero = 1'b1;
          if (stat.fr_ok) begin
            cmd.load_free  = 1'b1;
            phase_free_nxt = 1'b1;
            state_nxt      = S_PREP;
          end else begin
            state_nxt = S_RESP;
          end
        end else if (need_free && stat.fits_inplace) begin
          cmd.set_st   = 1'b1;
          cmd.st       = ST_KEPT;
          cmd.res_keep = 1'b1;
          state_nxt    = S_RESP;
        end else begin
          state_nxt = S_FIT;
        end
      end
      S_FIT: begin
        cmd.fit   = 1'b1;
        state_nxt = S_TAKE;
      end
      S_TAKE: begin
        if (!stat.fit_any) begin
          cmd.set_st   = 1'b1;
          cmd.st       = ST_OOM;
          cmd.res_zero = 1'b1;
          state_nxt    = S_RESP;
        end else begin
          cmd.take = 1'b1;
          if (stat.split) begin
            cmd.load_split = 1'b1;
            phase_free_nxt = 1'b0;
            state_nxt      = S_PREP;
          end else if (need_free && stat.fr_ok) begin
            cmd.load_free  = 1'b1;
            phase_free_nxt = 1'b1;
            state_nxt      = S_PREP;
          end else begin
            cmd.set_st = 1'b1;
            cmd.st     = need_free ? ST_MOVED : ST_OK;
            state_nxt  = S_RESP;
          end
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        if (phase_free_r) begin
          cmd.used_sub = 1'b1;
          cmd.set_st   = 1'b1;
          if (!stat.add_ok) cmd.st = ST_FULL;
          else              cmd.st = need_free ? ST_MOVED : ST_OK;
          state_nxt = S_RESP;
        end else if (need_free && stat.fr_ok) begin
          cmd.load_free  = 1'b1;
          phase_free_nxt = 1'b1;
          state_nxt      = S_PREP;
        end else begin
          cmd.set_st = 1'b1;
          cmd.st     = need_free ? ST_MOVED : ST_OK;
          state_nxt  = S_RESP;
        end
      end
      S_RESP: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      phase_free_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      phase_free_r <= phase_free_nxt;
    end
  end

endmodule

>>> rtl/ffca_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffca_dp
// free table, request registers, counters and result register
// ----------------------------------------------------------------------------
module ffca_dp import ffca_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  input  logic [1:0]  in_op,
  input  logic [20:0] in_req,
  input  logic [19:0] in_addr,
  input  logic [20:0] in_bsz,
  input  logic        cfg_wr_en,
  input  logic [20:0] cfg_wr_data,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,
  output logic [2:0]  out_tuser
);

  // free table rows, valid rows form a prefix of length cnt_r
  logic [19:0] start_r [TBL_DEPTH];
  logic [20:0] len_r   [TBL_DEPTH];
  logic [19:0] start_nxt [TBL_DEPTH];
  logic [20:0] len_nxt   [TBL_DEPTH];
  logic [19:0] nb_s [TBL_DEPTH];
  logic [20:0] nb_l [TBL_DEPTH];
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic [20:0] heap_r;
  logic [20:0] used_r, used_nxt, peak_r, peak_nxt;

  // captured request
  logic [1:0]  op_r;
  logic [19:0] addr_r;
  logic [20:0] bsz_r;
  logic [21:0] sz_r;
  logic        fits_r, frok_r;
  logic [21:0] sz_c, rnd_c;
  logic [21:0] fend_c;

  // search and insert state
  logic [TBL_DEPTH-1:0] fit_r, koh, atk;
  logic [TBL_DEPTH-1:0] ge_r, eq_r, pr_r;
  logic [TBL_DEPTH:0]   nge, posoh;
  logic [TBL_DEPTH-1:0] atpos;
  logic [21:0] add_s_r, add_l_r;
  logic [22:0] sl_c;
  logic        mnext, mprev, add_ok;
  logic [19:0] blk_s;
  logic [20:0] blk_l;
  logic        split_c;
  logic [21:0] grant_c;
  logic [21:0] used_sum;
  logic [20:0] heap_c;

  // result
  logic [19:0] res_pa_r;
  logic [20:0] res_gr_r;
  logic [2:0]  res_st_r;
  logic        out_tvalid_r;
  logic [87:0] out_tdata_r;
  logic [2:0]  out_tuser_r;

  assign rnd_c  = ({1'b0, in_req} + 22'd15) & ~22'd15;
  assign sz_c   = (rnd_c + HDR_BYTES < FREE_HDR_BYTES) ? FREE_HDR_BYTES : rnd_c + HDR_BYTES;
  assign fend_c = {2'b0, in_addr} - HDR_BYTES + {1'b0, in_bsz};

  assign heap_c = (cfg_wr_data < HEAP_MIN) ? HEAP_MIN :
                  (cfg_wr_data > HEAP_MAX) ? HEAP_MAX : cfg_wr_data;

  // first fitting row and its removal mask
  always_comb begin
    koh    = fit_r & (~fit_r + 1'b1);
    atk    = '0;
    blk_s  = '0;
    blk_l  = '0;
    atk[0] = koh[0];
    for (int i = 1; i < TBL_DEPTH; i++) begin
      atk[i] = atk[i-1] | koh[i];
    end
    for (int i = 0; i < TBL_DEPTH; i++) begin
      blk_s  = blk_s | (start_r[i] & {20{koh[i]}});
      blk_l  = blk_l | (len_r[i] & {21{koh[i]}});
    end
  end

  assign split_c  = {2'b0, blk_l} >= {1'b0, sz_r} + {1'b0, FREE_HDR_BYTES};
  assign grant_c  = split_c ? sz_r : {1'b0, blk_l};
  assign used_sum = {1'b0, used_r} + grant_c;

  // insert position and neighbour merges
  assign sl_c  = {1'b0, add_s_r} + {1'b0, add_l_r};
  assign nge   = {1'b1, ~ge_r};
  assign posoh = nge & (~nge + 1'b1);
  assign mnext = |(eq_r & posoh[TBL_DEPTH-1:0]);
  assign mprev = |(pr_r & posoh[TBL_DEPTH:1]);
  assign add_ok = mnext || mprev || (cnt_r != TBL_FULL);

  always_comb begin
    atpos    = '0;
    atpos[0] = posoh[0];
    for (int i = 1; i < TBL_DEPTH; i++) begin
      atpos[i] = atpos[i-1] | posoh[i];
    end
    for (int i = 0; i < TBL_DEPTH - 1; i++) begin
      nb_s[i] = start_r[i+1];
      nb_l[i] = len_r[i+1];
    end
    nb_s[TBL_DEPTH-1] = '0;
    nb_l[TBL_DEPTH-1] = '0;
  end

  // next table contents
  always_comb begin
    cnt_nxt = cnt_r;
    for (int i = 0; i < TBL_DEPTH; i++) begin
      start_nxt[i] = start_r[i];
      len_nxt[i]   = len_r[i];
    end
    if (cfg_wr_en) begin
      cnt_nxt = 6'd1;
      for (int i = 0; i < TBL_DEPTH; i++) begin
        start_nxt[i] = '0;
        len_nxt[i]   = '0;
      end
      len_nxt[0] = heap_c;
    end else if (cmd.take) begin
      cnt_nxt = cnt_r - 1'b1;
      for (int i = 0; i < TBL_DEPTH; i++) begin
        if (atk[i]) begin
          start_nxt[i] = nb_s[i];
          len_nxt[i]   = nb_l[i];
        end
      end
    end else if (cmd.apply) begin
      if (mnext && mprev) begin
        cnt_nxt = cnt_r - 1'b1;
        for (int i = 0; i < TBL_DEPTH; i++) begin
          if (posoh[i+1]) begin
            len_nxt[i] = len_r[i] + add_l_r[20:0] + nb_l[i];
          end else if (atpos[i]) begin
            start_nxt[i] = nb_s[i];
            len_nxt[i]   = nb_l[i];
          end
        end
      end else if (mprev) begin
        for (int i = 0; i < TBL_DEPTH; i++) begin
          if (posoh[i+1]) len_nxt[i] = len_r[i] + add_l_r[20:0];
        end
      end else if (mnext) begin
        for (int i = 0; i < TBL_DEPTH; i++) begin
          if (posoh[i]) begin
            start_nxt[i] = add_s_r[19:0];
            len_nxt[i]   = len_r[i] + add_l_r[20:0];
          end
        end
      end else if (cnt_r != TBL_FULL) begin
        cnt_nxt = cnt_r + 1'b1;
        for (int i = 0; i < TBL_DEPTH; i++) begin
          if (posoh[i]) begin
            start_nxt[i] = add_s_r[19:0];
            len_nxt[i]   = add_l_r[20:0];
          end else if (atpos[i] && i > 0) begin
            start_nxt[i] = start_r[(i > 0) ? i - 1 : 0];
            len_nxt[i]   = len_r[(i > 0) ? i - 1 : 0];
          end
        end
      end
    end
  end

  // byte counters
  always_comb begin
    used_nxt = used_r;
    peak_nxt = peak_r;
    if (cfg_wr_en) begin
      used_nxt = '0;
    end else if (cmd.take) begin
      used_nxt = used_sum[21] ? CNT_MAX : used_sum[20:0];
      if (used_nxt > peak_r) peak_nxt = used_nxt;
    end else if (cmd.used_sub && add_ok) begin
      used_nxt = (bsz_r > used_r) ? '0 : used_r - bsz_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 6'd1;
      heap_r <= HEAP_RST;
      used_r <= '0;
      peak_r <= '0;
      for (int i = 0; i < TBL_DEPTH; i++) begin
        start_r[i] <= '0;
        len_r[i]   <= '0;
      end
      len_r[0] <= HEAP_RST;
    end else begin
      cnt_r  <= cnt_nxt;
      used_r <= used_nxt;
      peak_r <= peak_nxt;
      if (cfg_wr_en) heap_r <= heap_c;
      for (int i = 0; i < TBL_DEPTH; i++) begin
        start_r[i] <= start_nxt[i];
        len_r[i]   <= len_nxt[i];
      end
    end
  end

  // request capture, search vectors, operands and result
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_op;
      addr_r <= in_addr;
      bsz_r  <= in_bsz;
      sz_r   <= sz_c;
      fits_r <= {1'b0, in_bsz} >= {1'b0, in_req} + HDR_BYTES;
      frok_r <= (in_addr >= 20'd16) && (in_bsz != '0) && (fend_c <= {1'b0, heap_r});
    end
    if (cmd.fit) begin
      for (int i = 0; i < TBL_DEPTH; i++) begin
        fit_r[i] <= (i < int'(cnt_r)) && ({1'b0, len_r[i]} >= sz_r);
      end
    end
    if (cmd.prep) begin
      for (int i = 0; i < TBL_DEPTH; i++) begin
        ge_r[i] <= (i < int'(cnt_r)) && ({2'b0, start_r[i]} <= add_s_r);
        eq_r[i] <= (i < int'(cnt_r)) && ({3'b0, start_r[i]} == sl_c);
        pr_r[i] <= (i < int'(cnt_r)) && ({2'b0, start_r[i]} + {1'b0, len_r[i]} == add_s_r);
      end
    end
    if (cmd.load_split) begin
      add_s_r <= {2'b0, blk_s} + sz_r;
      add_l_r <= {1'b0, blk_l} - sz_r;
    end else if (cmd.load_free) begin
      add_s_r <= {2'b0, addr_r} - HDR_BYTES;
      add_l_r <= {1'b0, bsz_r};
    end
    if (cmd.take) begin
      res_pa_r <= blk_s + 20'd16;
      res_gr_r <= grant_c[20:0];
    end else if (cmd.res_zero) begin
      res_pa_r <= '0;
      res_gr_r <= '0;
    end else if (cmd.res_keep) begin
      res_pa_r <= addr_r;
      res_gr_r <= bsz_r;
    end
    if (cmd.set_st) res_st_r <= cmd.st;
    if (cmd.out_load) begin
      out_tdata_r <= {5'b0, peak_r, used_r, res_gr_r, res_pa_r};
      out_tuser_r <= res_st_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  assign stat.op           = op_r;
  assign stat.addr_none    = (addr_r == '0);
  assign stat.fits_inplace = fits_r;
  assign stat.fr_ok        = frok_r;
  assign stat.fit_any      = |fit_r;
  assign stat.split        = split_c;
  assign stat.add_ok       = add_ok;
  assign stat.out_busy     = out_tvalid_r && !out_tready;

endmodule

>>> rtl/ffca_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffca_checker
// port-level checks on the allocator result channel
// ----------------------------------------------------------------------------
`include "first_fit_coalescing_allocator_unit_defines.svh"

module ffca_checker import ffca_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [87:0] out_tdata,
  input logic [2:0]  out_tuser
);

  `FFCA_ASSERT_RST(a_rst_idle, !rst_n |=> !out_tvalid, "result valid after reset")
  `FFCA_ASSERT(a_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled item changed")
  `FFCA_ASSERT(a_peak, out_tvalid |-> out_tdata[61:41] <= out_tdata[82:62], "used above peak")
  `FFCA_ASSERT(a_oom, out_tvalid && out_tuser == ST_OOM |-> out_tdata[40:0] == '0, "failed alloc returned a block")

endmodule

bind first_fit_coalescing_allocator_unit ffca_checker u_ffca_checker (.*);

>>> verif/first_fit_coalescing_allocator_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_coalescing_allocator_unit_checker
// watches request and result items, predicts each result, compares fields
// ----------------------------------------------------------------------------
module first_fit_coalescing_allocator_unit_checker import ffca_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [20:0] cfg_wr_data,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [87:0] out_tdata,
  input  logic [2:0]  out_tuser,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [19:0] addr;
    logic [20:0] granted;
    logic [2:0]  st;
    logic [20:0] used;
    logic [20:0] peak;
  } alloc_result_t;

  alloc_result_t results_due[$];
  longint        heap_sz;
  longint        blk_start [TBL_DEPTH];
  longint        blk_len [TBL_DEPTH];
  int            blk_count;
  longint        used_b;
  longint        peak_b;

  assign pending = results_due.size();

  function automatic void heap_reload();
    blk_count = 1;
    blk_start[0] = 0;
    blk_len[0] = heap_sz;
    used_b = 0;
  endfunction

  function automatic void drop_entry(int pos);
    for (int i = pos; i + 1 < blk_count; i++) begin
      blk_start[i] = blk_start[i+1];
      blk_len[i] = blk_len[i+1];
    end
    blk_count--;
  endfunction

  // sorted insert with merging on both sides, 0 when the table is full
  function automatic bit insert_region(longint s, longint l);
    int  pos;
    bit  join_next, join_prev;
    pos = 0;
    while (pos < blk_count && blk_start[pos] <= s) pos++;
    join_next = pos < blk_count && s + l == blk_start[pos];
    join_prev = pos > 0 && blk_start[pos-1] + blk_len[pos-1] == s;
    if (join_next && join_prev) begin
      blk_len[pos-1] += l + blk_len[pos];
      drop_entry(pos);
    end else if (join_prev) begin
      blk_len[pos-1] += l;
    end else if (join_next) begin
      blk_start[pos] = s;
      blk_len[pos] += l;
    end else begin
      if (blk_count >= TBL_DEPTH) return 0;
      for (int i = blk_count; i > pos; i--) begin
        blk_start[i] = blk_start[i-1];
        blk_len[i] = blk_len[i-1];
      end
      blk_start[pos] = s;
      blk_len[pos] = l;
      blk_count++;
    end
    return 1;
  endfunction

  function automatic bit take_region(longint req, output longint s, output longint got);
    longint sz, l;
    int     i;
    s = 0;
    got = 0;
    sz = ((req + 15) & ~longint'(15)) + 16;
    if (sz < 32) sz = 32;
    for (i = 0; i < blk_count; i++) if (blk_len[i] >= sz) break;
    if (i >= blk_count) return 0;
    s = blk_start[i];
    l = blk_len[i];
    drop_entry(i);
    if (l >= sz + 32) void'(insert_region(s + sz, l - sz));
    else sz = l;
    used_b = (used_b + sz > CNT_MAX) ? CNT_MAX : used_b + sz;
    if (used_b > peak_b) peak_b = used_b;
    got = sz;
    return 1;
  endfunction

  function automatic logic [2:0] release_block(longint a, longint sz);
    if (a < 16 || sz == 0) return ST_OK;
    if (a - 16 + sz > heap_sz) return ST_OK;
    if (!insert_region(a - 16, sz)) return ST_FULL;
    used_b = (sz > used_b) ? 0 : used_b - sz;
    return ST_OK;
  endfunction

  function automatic alloc_result_t predict_result(logic [1:0] op, longint req,
                                                   longint a, longint bsz);
    alloc_result_t r;
    longint        s, g;
    r = '0;
    if (op == OP_ALLOC || (op == OP_RESIZE && a == 0)) begin
      if (take_region(req, s, g)) begin
        r.addr = 20'(s + 16);
        r.granted = 21'(g);
      end else r.st = ST_OOM;
    end else if (op == OP_FREE) begin
      r.st = release_block(a, bsz);
    end else if (op == OP_RESIZE) begin
      if (bsz >= req + 16) begin
        r.addr = 20'(a);
        r.granted = 21'(bsz);
        r.st = ST_KEPT;
      end else if (take_region(req, s, g)) begin
        r.addr = 20'(s + 16);
        r.granted = 21'(g);
        r.st = (release_block(a, bsz) == ST_FULL) ? ST_FULL : ST_MOVED;
      end else r.st = ST_OOM;
    end
    r.used = 21'(used_b);
    r.peak = 21'(peak_b);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    heap_sz = longint'(HEAP_RST);
    peak_b = 0;
    heap_reload();
  end

  always @(posedge clk) begin
    alloc_result_t want, got;
    longint        v;
    if (!rst_n) begin
      heap_sz = longint'(HEAP_RST);
      peak_b = 0;
      heap_reload();
      results_due.delete();
    end else begin
      if (cfg_wr_en) begin
        v = longint'(cfg_wr_data);
        if (v < 64) v = 64;
        if (v > HEAP_MAX) v = longint'(HEAP_MAX);
        heap_sz = v;
        heap_reload();
      end
      if (in_tvalid && in_tready)
        results_due.insert(results_due.size(),
                           predict_result(in_tuser, longint'(in_tdata[20:0]),
                                          longint'(in_tdata[40:21]),
                                          longint'(in_tdata[61:41])));
      if (out_tvalid && out_tready) begin
        got.addr = out_tdata[19:0];
        got.granted = out_tdata[40:20];
        got.used = out_tdata[61:41];
        got.peak = out_tdata[82:62];
        got.st = out_tuser;
        if (results_due.size() == 0) begin
          report_mismatch("unexpected result item", 1, 0);
        end else begin
          want = results_due.pop_front();
          if (got.addr != want.addr)
            report_mismatch("payload_address", longint'(got.addr), longint'(want.addr));
          if (got.granted != want.granted)
            report_mismatch("granted_bytes", longint'(got.granted), longint'(want.granted));
          if (got.st != want.st)
            report_mismatch("status", longint'(got.st), longint'(want.st));
          if (got.used != want.used)
            report_mismatch("used_bytes", longint'(got.used), longint'(want.used));
          if (got.peak != want.peak)
            report_mismatch("peak_bytes", longint'(got.peak), longint'(want.peak));
        end
      end
    end
  end

endmodule

>>> verif/first_fit_coalescing_allocator_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_coalescing_allocator_unit_tb
// drives allocate, free and resize requests through the allocator under
// random idling and back-pressure; the checker predicts and compares
// ----------------------------------------------------------------------------
module first_fit_coalescing_allocator_unit_tb;
  import ffca_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_wr_en = 0;
  logic [20:0] cfg_wr_data = '0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic [1:0]  in_tuser = OP_ALLOC;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [87:0] out_tdata;
  logic [2:0]  out_tuser;
  int          fail_count;
  int          pending;

  // idle percentages of each side, changed between phases
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          recv_hold = 0;

  // blocks currently held by the stimulus: payload address and size
  logic [19:0] held_addr[$];
  logic [20:0] held_size[$];

  always #4 clk = ~clk;

  first_fit_coalescing_allocator_unit uut (.*);

  first_fit_coalescing_allocator_unit_checker chk (.*);

  // receiver: random back-pressure, or a forced hold-off
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 0;
    else out_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // the stimulus learns granted blocks from the result items it sees
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready && out_tdata[19:0] != 0 &&
        out_tuser != ST_KEPT && out_tuser != ST_OOM) begin
      held_addr.insert(held_addr.size(), out_tdata[19:0]);
      held_size.insert(held_size.size(), out_tdata[40:20]);
    end
  end

  // one request item; random gap first, returns at the accepting edge with
  // valid still high so that the next item can follow without a gap
  task automatic send_request(logic [1:0] op, logic [20:0] req, logic [19:0] a,
                              logic [20:0] bsz);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= op;
    in_tdata <= {2'b0, bsz, a, req};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // a result may still be leaving the output register
    repeat (20) @(posedge clk);
  endtask

  task automatic write_heap(logic [20:0] v);
    wait_drained();
    held_addr.delete();
    held_size.delete();
    cfg_wr_en <= 1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 0;
    @(posedge clk);
  endtask

  // mostly well-formed traffic from the held list, some noise
  task automatic random_request();
    int k, sel;
    sel = $urandom_range(99);
    if (held_addr.size() > 0 && sel < 40) begin
      k = $urandom_range(held_addr.size() - 1);
      send_request(OP_FREE, 0, held_addr[k], held_size[k]);
      held_addr.delete(k);
      held_size.delete(k);
    end else if (held_addr.size() > 0 && sel < 55) begin
      k = $urandom_range(held_addr.size() - 1);
      send_request(OP_RESIZE, 21'($urandom_range(600)), held_addr[k], held_size[k]);
      held_addr.delete(k);
      held_size.delete(k);
    end else if (sel < 92) begin
      send_request(OP_ALLOC, 21'(($urandom_range(3) == 0) ? $urandom_range(9000)
                   : $urandom_range(300)), 0, 0);
    end else begin
      // raw noise over every bit of every field
      send_request(2'($urandom_range(3)), 21'($urandom), 20'($urandom), 21'($urandom));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed part: extremes, every operation, special cases
    send_request(OP_ALLOC, 0, 0, 0);
    send_request(OP_ALLOC, 21'h1FFFFF, 0, 0);
    send_request(OP_ALLOC, 17, 0, 0);
    send_request(OP_FREE, 0, 0, 0);
    send_request(OP_FREE, 0, 8, 32);
    send_request(OP_FREE, 0, 20'hFFFFF, 21'h1FFFFF);
    send_request(OP_FREE, 0, 64, 0);
    send_request(OP_NONE, 21'h1FFFFF, 20'hFFFFF, 21'h1FFFFF);
    send_request(OP_RESIZE, 100, 0, 0);
    send_request(OP_RESIZE, 10, 16, 48);
    send_request(OP_RESIZE, 21'h1FFFFF, 16, 32);
    send_request(OP_RESIZE, 200, 16, 32);
    wait_drained();
    // fragment the table until frees overflow it
    write_heap(21'h1FFFFF);
    for (int i = 0; i < 70; i++) send_request(OP_ALLOC, 16, 0, 0);
    for (int i = 0; i < 70; i += 2) send_request(OP_FREE, 0, 20'(16 + 32 * i), 32);
    send_request(OP_RESIZE, 40, 20'(16 + 32 * 71), 32);
    write_heap(0);
    send_request(OP_ALLOC, 32, 0, 0);
    send_request(OP_ALLOC, 0, 0, 0);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 11 : (ph == 1) ? 60 : 0;
      recv_idle_pct = (ph == 0) ? 60 : (ph == 1) ? 11 : 0;
      write_heap((ph == 0) ? 21'd65536 : (ph == 1) ? 21'd4096 : 21'h100000);
      for (int i = 0; i < 190; i++) begin
        random_request();
        if (i == 100) begin
          // long hold-off on the receiver while requests keep coming
          fork
            begin
              recv_hold = 1;
              repeat (150) @(posedge clk);
              recv_hold = 0;
            end
            for (int j = 0; j < 6; j++) random_request();
          join
        end
        // sender pause until every result is back
        if (i == 180) wait_drained();
      end
    end

    wait_drained();
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

endmodule
